/* hw/rtl/dor_pkg.sv */
package dor_pkg;

    // Fixed field widths of the item and result ports
    localparam int CHAN_BITS  = 8;
    localparam int OP_BITS    = 2;
    localparam int AO_BITS    = 3;
    localparam int FIELD_BITS = 48;

    // Width used to sign-extend values between field and arithmetic widths
    localparam int EXT_BITS = 64;

    // Defaults for the top-level parameters
    localparam int DEF_ORDER_DEPTH = 8;
    localparam int DEF_CHANNELS    = 256;
    localparam int DEF_VALUE_BITS  = 48;

    // Item opcodes
    typedef enum logic [OP_BITS-1:0] {
        OP_DIFF  = 2'd0,
        OP_ARC   = 2'd1,
        OP_BLANK = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

endpackage

/* hw/rtl/difference_order_reconstructor_unit.sv */
// Channel    | Direction | Handshake          | Payload
// input      | in        | i_valid / o_ready  | i_channel, i_opcode, i_arc_order, i_number
// result     | out       | o_valid / i_ready  | o_channel_out, o_recovered, o_present, o_status
//
// One transaction at a time. Arc start, blank, clear, an error difference and an
// out-of-range channel pass through S_META and S_DONE before o_ready returns; a
// difference that reaches order k (k <= ORDER_DEPTH - 1) also passes through k
// fold steps in S_FOLD, through the single adder and the difference memory port.
// After reset all CHANNELS entries of the channel table are swept with o_ready low.
// A stalled result waits in the output register; the block still takes the
// next transaction and only holds it at the end if the result is not yet taken.
module difference_order_reconstructor_unit #(
    parameter int ORDER_DEPTH = dor_pkg::DEF_ORDER_DEPTH,
    parameter int CHANNELS    = dor_pkg::DEF_CHANNELS,
    parameter int VALUE_BITS  = dor_pkg::DEF_VALUE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [dor_pkg::CHAN_BITS-1:0]          i_channel,
    input  logic [dor_pkg::OP_BITS-1:0]            i_opcode,
    input  logic [dor_pkg::AO_BITS-1:0]            i_arc_order,
    input  logic signed [dor_pkg::FIELD_BITS-1:0]  i_number,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [dor_pkg::CHAN_BITS-1:0]          o_channel_out,
    output logic signed [dor_pkg::FIELD_BITS-1:0]  o_recovered,
    output logic                                   o_present,
    output logic                                   o_status
);
    import dor_pkg::*;

    localparam int OW         = $clog2(ORDER_DEPTH);
    localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIFF_DEPTH = CHANNELS * (2 ** OW);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_META  = 5'b00100,
        S_FOLD  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Per-channel control word: live flag, order reached, arc order
    typedef struct packed {
        logic          live;
        logic [OW-1:0] order;
        logic [OW-1:0] arc;
    } t_meta;

    // Control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_clr, n_clr;
    logic          r_ov, n_ov;

    // Transaction and working registers
    logic [CHAN_BITS-1:0]  r_chan, n_chan;
    t_opcode               r_op, n_op;
    logic [AO_BITS-1:0]    r_ao, n_ao;
    logic [VALUE_BITS-1:0] r_num, n_num;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [OW-1:0]         r_idx, n_idx;
    logic [FIELD_BITS-1:0] r_res_rec, n_res_rec;
    logic                  r_res_present, n_res_present;
    logic                  r_res_status, n_res_status;

    // Output register
    logic [CHAN_BITS-1:0]  r_och, n_och;
    logic [FIELD_BITS-1:0] r_orec, n_orec;
    logic                  r_opres, n_opres;
    logic                  r_ostat, n_ostat;

    // Memories and their ports
    t_meta                 r_meta_mem [CHANNELS];
    t_meta                 r_meta_q;
    logic                  meta_we;
    logic [CW-1:0]         meta_waddr;
    logic [CW-1:0]         meta_raddr;
    t_meta                 meta_wdata;

    logic [VALUE_BITS-1:0] r_diff_mem [DIFF_DEPTH];
    logic [VALUE_BITS-1:0] r_diff_q;
    logic                  diff_we;
    logic [CW+OW-1:0]      diff_waddr;
    logic [CW+OW-1:0]      diff_raddr;
    logic [VALUE_BITS-1:0] diff_wdata;

    // Datapath helpers
    logic signed [EXT_BITS-1:0] num_ext;
    logic [CW-1:0]              ch_idx;
    logic                       in_range;
    logic [OW-1:0]              ao_sat;
    logic [OW-1:0]              ord_new;
    logic [VALUE_BITS-1:0]      sum;
    logic                       accept;

    // Sign-extend or truncate a working value back to the result field
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
        logic signed [EXT_BITS-1:0] t;
        t = EXT_BITS'($signed(v));
        return t[FIELD_BITS-1:0];
    endfunction

    assign num_ext  = EXT_BITS'(i_number);
    assign ch_idx   = CW'(r_chan);
    assign in_range = (int'(r_chan) < CHANNELS);
    assign ao_sat   = (int'(r_ao) >= ORDER_DEPTH) ? OW'(ORDER_DEPTH - 1) : OW'(r_ao);
    assign ord_new  = (r_meta_q.order < r_meta_q.arc) ? OW'(r_meta_q.order + 1'b1)
                                                      : r_meta_q.order;
    // The one shared adder of the fold-down
    assign sum      = r_diff_q + r_acc;
    assign accept   = i_valid && o_ready;
    assign meta_raddr = CW'(i_channel);

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_channel_out = r_och;
    assign o_recovered   = r_orec;
    assign o_present     = r_opres;
    assign o_status      = r_ostat;

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_ov          = r_ov && !i_ready;
        n_chan        = r_chan;
        n_op          = r_op;
        n_ao          = r_ao;
        n_num         = r_num;
        n_acc         = r_acc;
        n_idx         = r_idx;
        n_res_rec     = r_res_rec;
        n_res_present = r_res_present;
        n_res_status  = r_res_status;
        n_och         = r_och;
        n_orec        = r_orec;
        n_opres       = r_opres;
        n_ostat       = r_ostat;
        meta_we       = 1'b0;
        meta_waddr    = ch_idx;
        meta_wdata    = r_meta_q;
        diff_we       = 1'b0;
        diff_waddr    = {ch_idx, r_idx};
        diff_wdata    = r_num;
        diff_raddr    = {ch_idx, r_idx};

        case (r_state)
            // Sweep the channel table to the uninitialised state
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == CW'(CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a transaction and start the channel table read
            S_IDLE: begin
                if (accept) begin
                    n_chan  = i_channel;
                    n_op    = t_opcode'(i_opcode);
                    n_ao    = i_arc_order;
                    n_num   = num_ext[VALUE_BITS-1:0];
                    n_state = S_META;
                end
            end

            // Apply the opcode to the channel control word
            S_META: begin
                n_res_rec     = '0;
                n_res_present = 1'b0;
                n_res_status  = 1'b0;
                n_state       = S_DONE;
                if (in_range) begin
                    case (r_op)
                        OP_ARC: begin
                            // Higher differences are written before they are read
                            // again, so only the value itself is stored here
                            meta_we       = 1'b1;
                            meta_wdata    = '{live: 1'b1, order: '0, arc: ao_sat};
                            diff_we       = 1'b1;
                            diff_waddr    = {ch_idx, {OW{1'b0}}};
                            diff_wdata    = r_num;
                            n_res_rec     = to_field(r_num);
                            n_res_present = 1'b1;
                        end
                        OP_BLANK: begin
                            meta_we         = 1'b1;
                            meta_wdata.live = 1'b0;
                        end
                        OP_CLEAR: begin
                            meta_we    = 1'b1;
                            meta_wdata = '0;
                        end
                        OP_DIFF: begin
                            if (!r_meta_q.live) begin
                                n_res_status = 1'b1;
                            end else begin
                                meta_we    = 1'b1;
                                meta_wdata = '{live: 1'b1, order: ord_new, arc: r_meta_q.arc};
                                diff_we    = 1'b1;
                                diff_waddr = {ch_idx, ord_new};
                                diff_wdata = r_num;
                                n_acc      = r_num;
                                if (ord_new == '0) begin
                                    // Order zero replaces the value outright
                                    n_res_rec     = to_field(r_num);
                                    n_res_present = 1'b1;
                                end else begin
                                    n_idx      = ord_new - 1'b1;
                                    diff_raddr = {ch_idx, OW'(ord_new - 1'b1)};
                                    n_state    = S_FOLD;
                                end
                            end
                        end
                        default: begin
                            n_res_status = 1'b0;
                        end
                    endcase
                end
            end

            // Fold one difference down per cycle
            S_FOLD: begin
                diff_we    = 1'b1;
                diff_waddr = {ch_idx, r_idx};
                diff_wdata = sum;
                n_acc      = sum;
                if (r_idx == '0) begin
                    n_res_rec     = to_field(sum);
                    n_res_present = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_idx      = r_idx - 1'b1;
                    diff_raddr = {ch_idx, OW'(r_idx - 1'b1)};
                end
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_och   = r_chan;
                    n_orec  = r_res_rec;
                    n_opres = r_res_present;
                    n_ostat = r_res_status;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_chan        <= n_chan;
        r_op          <= n_op;
        r_ao          <= n_ao;
        r_num         <= n_num;
        r_acc         <= n_acc;
        r_idx         <= n_idx;
        r_res_rec     <= n_res_rec;
        r_res_present <= n_res_present;
        r_res_status  <= n_res_status;
        r_och         <= n_och;
        r_orec        <= n_orec;
        r_opres       <= n_opres;
        r_ostat       <= n_ostat;
    end

    // Channel control table
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= r_meta_mem[meta_raddr];
    end

    // Difference store, one row of 2**OW entries per channel
    always_ff @(posedge i_clk) begin
        if (diff_we) begin
            r_diff_mem[diff_waddr] <= diff_wdata;
        end
        r_diff_q <= r_diff_mem[diff_raddr];
    end

endmodule

/* hw/rtl/dor_checker.sv */
module dor_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic [dor_pkg::CHAN_BITS-1:0]          o_channel_out,
    input logic signed [dor_pkg::FIELD_BITS-1:0]  o_recovered,
    input logic                                   o_present,
    input logic                                   o_status
);
    import dor_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_recovered) &&
            $stable(o_channel_out) && $stable(o_present) && $stable(o_status))
        else $error("result changed while stalled");

    // An absent channel reports a zero value
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_present |-> o_recovered == '0)
        else $error("nonzero value on absent channel");

    // An error result never shows a live channel
    a_error_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_present)
        else $error("error result marked present");

    // Not ready in the cycle after each transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after a transaction");

    // Table sweep follows reset
    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid right after reset");

endmodule

bind difference_order_reconstructor_unit dor_checker u_dor_checker (.*);
